[design/rvmu_pkg.sv]
`default_nettype none
package rvmu_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int NUM_W  = 2 * DATA_W + 1;
  localparam int FRAC_W = 16;
  localparam int CNT_W  = $clog2(DATA_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] UNITY = DATA_W'(1) << FRAC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VOLUME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VFA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_OP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_AEROBIC = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_KEEP,
    ST_MUL_FRESH,
    ST_MIX,
    ST_DIV_LVL,
    ST_FACTOR,
    ST_DIV_FAC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

[design/rvmu_in_if.sv]
`default_nettype none
interface rvmu_in_if;
  logic                       valid;
  logic                       ready;
  logic                       restart;
  logic [rvmu_pkg::DATA_W-1:0] inflow_volume;
  logic [rvmu_pkg::DATA_W-1:0] withdraw_volume;
  logic [rvmu_pkg::DATA_W-1:0] outflow_volume;
  logic [rvmu_pkg::DATA_W-1:0] inflow_vfa;
  logic [rvmu_pkg::DATA_W-1:0] inflow_op;
  logic                       aeration;

  modport source (
    output valid, restart, inflow_volume, withdraw_volume, outflow_volume,
           inflow_vfa, inflow_op, aeration,
    input  ready
  );
  modport sink (
    input  valid, restart, inflow_volume, withdraw_volume, outflow_volume,
           inflow_vfa, inflow_op, aeration,
    output ready
  );
endinterface
`default_nettype wire

[design/rvmu_out_if.sv]
`default_nettype none
interface rvmu_out_if;
  logic                       valid;
  logic                       ready;
  logic [rvmu_pkg::DATA_W-1:0] volume_out;
  logic [rvmu_pkg::DATA_W-1:0] vfa_out;
  logic [rvmu_pkg::DATA_W-1:0] op_out;
  logic                       aerobic_out;
  logic                       washed_out;
  logic [rvmu_pkg::DATA_W-1:0] biomass_factor;

  modport source (
    output valid, volume_out, vfa_out, op_out, aerobic_out, washed_out,
           biomass_factor,
    input  ready
  );
  modport sink (
    input  valid, volume_out, vfa_out, op_out, aerobic_out, washed_out,
           biomass_factor,
    output ready
  );
endinterface
`default_nettype wire

[design/rvmu_cfg_if.sv]
`default_nettype none
interface rvmu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rvmu_pkg::CFG_IDX_W-1:0] index;
  logic [rvmu_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/rvmu_mul.sv]
`default_nettype none
module rvmu_mul (
  input  wire logic                        clk,
  input  wire logic [rvmu_pkg::DATA_W-1:0] a,
  input  wire logic [rvmu_pkg::DATA_W-1:0] b,
  output logic      [rvmu_pkg::PROD_W-1:0] p
);

  logic [rvmu_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= rvmu_pkg::PROD_W'(a) * rvmu_pkg::PROD_W'(b);
  end

  assign p = p_r;

endmodule
`default_nettype wire

[design/rvmu_div.sv]
`default_nettype none
module rvmu_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rvmu_pkg::NUM_W-1:0]  num,
  input  wire logic [rvmu_pkg::DATA_W-1:0] den,
  output rvmu_pkg::div_stat_t              stat,
  output logic      [rvmu_pkg::DATA_W-1:0] quo
);

  localparam int DW = rvmu_pkg::DATA_W;

  logic                         busy_r, busy_nxt;
  logic [rvmu_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DW-1:0]                rem_r, rem_nxt;
  logic [DW-1:0]                q_r, q_nxt;
  logic [DW-1:0]                den_r, den_nxt;
  logic [DW:0]                  shifted;
  logic                         ge;
  logic                         sat;

  assign shifted = {rem_r, q_r[DW-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign sat     = num[rvmu_pkg::NUM_W-1:DW] >= {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      den_nxt  = den;
      rem_nxt  = num[2*DW-1:DW];
      if (sat) begin
        cnt_nxt = '0;
        q_nxt   = '1;
      end else begin
        cnt_nxt = rvmu_pkg::CNT_W'(DW);
        q_nxt   = num[DW-1:0];
      end
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        rem_nxt = ge ? DW'(shifted - {1'b0, den_r}) : shifted[DW-1:0];
        q_nxt   = {q_r[DW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == '0);
  assign quo       = q_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0 || start) else $error("divider count left over");
  a_done_drop: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done && !start |=> !busy_r) else $error("divider stays busy after done");

endmodule
`default_nettype wire

[design/reactor_volume_mixing_update_unit.sv]
`default_nettype none
// on restart or washout the input goes straight to the output step; otherwise the result
// follows the multiply and divide steps (shorter when a quotient saturates or a level clamps to zero)
// the unit takes no new input transaction before its result is loaded into the result
// register; the input is not ready while busy or while the result register is held
// the run time is set mainly by up to three runs of the shared one-bit-per-cycle divider
// reset: synchronous active low; volume 1.0, levels zero, aerobic clear,
// init registers back to their reset values, result register empty
module reactor_volume_mixing_update_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  rvmu_in_if.sink    in_ch,
  rvmu_out_if.source out_ch,
  rvmu_cfg_if.sink   cfg_ch
);

  localparam int DW = rvmu_pkg::DATA_W;

  rvmu_pkg::state_t state_r, state_nxt;

  logic [DW-1:0] cfg_vol_r, cfg_vol_nxt;
  logic [DW-1:0] cfg_vfa_r, cfg_vfa_nxt;
  logic [DW-1:0] cfg_op_r, cfg_op_nxt;
  logic          cfg_aer_r, cfg_aer_nxt;

  logic [DW-1:0] vol_r, vol_nxt;
  logic [DW-1:0] vfa_r, vfa_nxt;
  logic [DW-1:0] op_r, op_nxt;
  logic          aerobic_r, aerobic_nxt;

  logic          sel_r, sel_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [DW-1:0]               vin_r, vin_nxt;
  logic [DW-1:0]               vw_r, vw_nxt;
  logic [DW-1:0]               cin_vfa_r, cin_vfa_nxt;
  logic [DW-1:0]               cin_op_r, cin_op_nxt;
  logic [DW-1:0]               v_r, v_nxt;
  logic [rvmu_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic [DW-1:0]               nvol_r, nvol_nxt;
  logic [DW-1:0]               nvfa_r, nvfa_nxt;
  logic [DW-1:0]               nop_r, nop_nxt;
  logic                        naer_r, naer_nxt;
  logic                        washed_r, washed_nxt;
  logic [DW-1:0]               factor_r, factor_nxt;
  logic [DW-1:0]               o_vol_r, o_vol_nxt;
  logic [DW-1:0]               o_vfa_r, o_vfa_nxt;
  logic [DW-1:0]               o_op_r, o_op_nxt;
  logic                        o_aer_r, o_aer_nxt;
  logic                        o_washed_r, o_washed_nxt;
  logic [DW-1:0]               o_factor_r, o_factor_nxt;

  logic                        in_fire;
  logic                        out_load;
  logic [DW+1:0]               gain;
  logic [DW+1:0]               loss;
  logic [DW+1:0]               diff;
  logic                        wash;
  logic [DW-1:0]               v_sat;
  logic                        v_ge_in;
  logic [rvmu_pkg::PROD_W-1:0] fresh;
  logic                        mix_zero;
  logic                        fac_pos;

  logic [DW-1:0]               mul_a, mul_b;
  logic [rvmu_pkg::PROD_W-1:0] mul_p;
  logic                        div_start;
  logic [rvmu_pkg::NUM_W-1:0]  div_num;
  rvmu_pkg::div_stat_t         div_st;
  logic [DW-1:0]               div_quo;

  rvmu_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rvmu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (v_r),
    .stat  (div_st),
    .quo   (div_quo)
  );

  assign in_ch.ready  = (state_r == rvmu_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == rvmu_pkg::ST_OUT) && (!out_valid_r || out_ch.ready);

  assign gain  = (DW+2)'(vol_r) + (DW+2)'(in_ch.inflow_volume);
  assign loss  = (DW+2)'(in_ch.withdraw_volume) + (DW+2)'(in_ch.outflow_volume);
  assign wash  = gain <= loss;
  assign diff  = gain - loss;
  assign v_sat = (diff[DW+1:DW] != 2'b00) ? '1 : diff[DW-1:0];

  assign v_ge_in  = v_r >= vin_r;
  assign fresh    = mul_p;
  assign mix_zero = !v_ge_in && (fresh <= acc_r);
  assign fac_pos  = vol_r > vw_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rvmu_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.restart || wash) state_nxt = rvmu_pkg::ST_OUT;
          else state_nxt = rvmu_pkg::ST_MUL_KEEP;
        end
      end
      rvmu_pkg::ST_MUL_KEEP:  state_nxt = rvmu_pkg::ST_MUL_FRESH;
      rvmu_pkg::ST_MUL_FRESH: state_nxt = rvmu_pkg::ST_MIX;
      rvmu_pkg::ST_MIX: begin
        if (!mix_zero) state_nxt = rvmu_pkg::ST_DIV_LVL;
        else if (sel_r) state_nxt = rvmu_pkg::ST_FACTOR;
        else state_nxt = rvmu_pkg::ST_MUL_KEEP;
      end
      rvmu_pkg::ST_DIV_LVL: begin
        if (div_st.done) begin
          if (sel_r) state_nxt = rvmu_pkg::ST_FACTOR;
          else state_nxt = rvmu_pkg::ST_MUL_KEEP;
        end
      end
      rvmu_pkg::ST_FACTOR: begin
        if (fac_pos) state_nxt = rvmu_pkg::ST_DIV_FAC;
        else state_nxt = rvmu_pkg::ST_OUT;
      end
      rvmu_pkg::ST_DIV_FAC: begin
        if (div_st.done) state_nxt = rvmu_pkg::ST_OUT;
      end
      rvmu_pkg::ST_OUT: begin
        if (out_load) state_nxt = rvmu_pkg::ST_IDLE;
      end
      default: state_nxt = rvmu_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    cfg_vol_nxt   = cfg_vol_r;
    cfg_vfa_nxt   = cfg_vfa_r;
    cfg_op_nxt    = cfg_op_r;
    cfg_aer_nxt   = cfg_aer_r;
    vol_nxt       = vol_r;
    vfa_nxt       = vfa_r;
    op_nxt        = op_r;
    aerobic_nxt   = aerobic_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    vin_nxt       = vin_r;
    vw_nxt        = vw_r;
    cin_vfa_nxt   = cin_vfa_r;
    cin_op_nxt    = cin_op_r;
    v_nxt         = v_r;
    acc_nxt       = acc_r;
    nvol_nxt      = nvol_r;
    nvfa_nxt      = nvfa_r;
    nop_nxt       = nop_r;
    naer_nxt      = naer_r;
    washed_nxt    = washed_r;
    factor_nxt    = factor_r;
    o_vol_nxt     = o_vol_r;
    o_vfa_nxt     = o_vfa_r;
    o_op_nxt      = o_op_r;
    o_aer_nxt     = o_aer_r;
    o_washed_nxt  = o_washed_r;
    o_factor_nxt  = o_factor_r;
    mul_a         = vin_r;
    mul_b         = sel_r ? cin_op_r : cin_vfa_r;
    div_start     = 1'b0;
    div_num       = '0;

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rvmu_pkg::CFG_INIT_VOLUME:  cfg_vol_nxt = cfg_ch.data;
        rvmu_pkg::CFG_INIT_VFA:     cfg_vfa_nxt = cfg_ch.data;
        rvmu_pkg::CFG_INIT_OP:      cfg_op_nxt  = cfg_ch.data;
        rvmu_pkg::CFG_INIT_AEROBIC: cfg_aer_nxt = cfg_ch.data[0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      rvmu_pkg::ST_IDLE: begin
        if (in_fire) begin
          vin_nxt     = in_ch.inflow_volume;
          vw_nxt      = in_ch.withdraw_volume;
          cin_vfa_nxt = in_ch.inflow_vfa;
          cin_op_nxt  = in_ch.inflow_op;
          v_nxt       = v_sat;
          sel_nxt     = 1'b0;
          if (in_ch.restart) begin
            nvol_nxt   = cfg_vol_r;
            nvfa_nxt   = cfg_vfa_r;
            nop_nxt    = cfg_op_r;
            naer_nxt   = cfg_aer_r;
            washed_nxt = 1'b0;
            factor_nxt = rvmu_pkg::UNITY;
          end else if (wash) begin
            nvol_nxt   = '0;
            nvfa_nxt   = '0;
            nop_nxt    = '0;
            naer_nxt   = aerobic_r;
            washed_nxt = 1'b1;
            factor_nxt = '0;
          end else begin
            nvol_nxt   = v_sat;
            naer_nxt   = in_ch.aeration;
            washed_nxt = 1'b0;
          end
        end
      end
      rvmu_pkg::ST_MUL_KEEP: begin
        mul_a = v_ge_in ? v_r - vin_r : vin_r - v_r;
        mul_b = sel_r ? op_r : vfa_r;
      end
      rvmu_pkg::ST_MUL_FRESH: begin
        acc_nxt = mul_p;
      end
      rvmu_pkg::ST_MIX: begin
        if (mix_zero) begin
          if (sel_r) nop_nxt = '0;
          else nvfa_nxt = '0;
          sel_nxt = 1'b1;
        end else begin
          div_start = 1'b1;
          if (v_ge_in) div_num = rvmu_pkg::NUM_W'(acc_r) + rvmu_pkg::NUM_W'(fresh);
          else div_num = rvmu_pkg::NUM_W'(fresh - acc_r);
        end
      end
      rvmu_pkg::ST_DIV_LVL: begin
        if (div_st.done) begin
          if (sel_r) nop_nxt = div_quo;
          else nvfa_nxt = div_quo;
          sel_nxt = 1'b1;
        end
      end
      rvmu_pkg::ST_FACTOR: begin
        if (fac_pos) begin
          div_start = 1'b1;
          div_num   = rvmu_pkg::NUM_W'({vol_r - vw_r, rvmu_pkg::FRAC_W'(0)});
        end else begin
          factor_nxt = '0;
        end
      end
      rvmu_pkg::ST_DIV_FAC: begin
        if (div_st.done) factor_nxt = div_quo;
      end
      rvmu_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          o_vol_nxt     = nvol_r;
          o_vfa_nxt     = nvfa_r;
          o_op_nxt      = nop_r;
          o_aer_nxt     = naer_r;
          o_washed_nxt  = washed_r;
          o_factor_nxt  = factor_r;
          vol_nxt       = nvol_r;
          vfa_nxt       = nvfa_r;
          op_nxt        = nop_r;
          aerobic_nxt   = naer_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rvmu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      cfg_vol_r   <= rvmu_pkg::UNITY;
      cfg_vfa_r   <= '0;
      cfg_op_r    <= '0;
      cfg_aer_r   <= 1'b0;
      vol_r       <= rvmu_pkg::UNITY;
      vfa_r       <= '0;
      op_r        <= '0;
      aerobic_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
      cfg_vol_r   <= cfg_vol_nxt;
      cfg_vfa_r   <= cfg_vfa_nxt;
      cfg_op_r    <= cfg_op_nxt;
      cfg_aer_r   <= cfg_aer_nxt;
      vol_r       <= vol_nxt;
      vfa_r       <= vfa_nxt;
      op_r        <= op_nxt;
      aerobic_r   <= aerobic_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vin_r      <= vin_nxt;
    vw_r       <= vw_nxt;
    cin_vfa_r  <= cin_vfa_nxt;
    cin_op_r   <= cin_op_nxt;
    v_r        <= v_nxt;
    acc_r      <= acc_nxt;
    nvol_r     <= nvol_nxt;
    nvfa_r     <= nvfa_nxt;
    nop_r      <= nop_nxt;
    naer_r     <= naer_nxt;
    washed_r   <= washed_nxt;
    factor_r   <= factor_nxt;
    o_vol_r    <= o_vol_nxt;
    o_vfa_r    <= o_vfa_nxt;
    o_op_r     <= o_op_nxt;
    o_aer_r    <= o_aer_nxt;
    o_washed_r <= o_washed_nxt;
    o_factor_r <= o_factor_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.volume_out     = o_vol_r;
  assign out_ch.vfa_out        = o_vfa_r;
  assign out_ch.op_out         = o_op_r;
  assign out_ch.aerobic_out    = o_aer_r;
  assign out_ch.washed_out     = o_washed_r;
  assign out_ch.biomass_factor = o_factor_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready) else $error("input ready right after a transaction");
  a_washout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.washed_out |->
      out_ch.volume_out == '0 && out_ch.vfa_out == '0 && out_ch.op_out == '0 &&
      out_ch.biomass_factor == '0) else $error("washout result not cleared");
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> vol_r == o_vol_r && vfa_r == o_vfa_r && op_r == o_op_r)
    else $error("state and result disagree");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> state_r == rvmu_pkg::ST_DIV_LVL || state_r == rvmu_pkg::ST_DIV_FAC)
    else $error("divider busy outside a divide step");

endmodule
`default_nettype wire
